// File: rtl/core/lerb_pkg.sv
package lerb_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int MAX_READ      = 64;

  localparam logic [7:0] KEY_ETX   = 8'd3;
  localparam logic [7:0] KEY_TAB   = 8'd9;
  localparam logic [7:0] KEY_FF    = 8'd12;
  localparam logic [7:0] KEY_CR    = 8'd13;
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_BS    = 8'd127;
  localparam logic [7:0] MARK_UP   = 8'd252;
  localparam logic [7:0] MARK_DOWN = 8'd254;

  localparam logic [6:0] LEN_MAX = 7'(MAX_READ);
  localparam logic [6:0] LC_MAX  = 7'd127;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_LINE      = 3'd0,
    KIND_TAB       = 3'd1,
    KIND_UP        = 3'd2,
    KIND_DOWN      = 3'd3,
    KIND_NOT_READY = 3'd4
  } kind_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] key_byte;
    logic [6:0] max_length;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    kind_t      read_kind;
    logic [6:0] byte_count;
  } result_t;

endpackage

// File: rtl/core/lerb_seq.sv
module lerb_seq #(
  parameter int DEPTH = lerb_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lerb_pkg::item_t   in_item,
  input  logic              cfg_we,
  input  logic              cfg_autocomplete,
  input  logic              out_free,
  output logic              emit,
  output lerb_pkg::result_t emit_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL     = FW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wi_r, wi_nxt;
  logic [AW-1:0]     ri_r, ri_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic [6:0]        lc_r, lc_nxt;
  logic              tab_r, tab_nxt;
  logic              up_r, up_nxt;
  logic              down_r, down_nxt;
  logic              ac_r, ac_nxt;
  logic [6:0]        len_r, len_nxt;
  logic [6:0]        n_r, n_nxt;
  lerb_pkg::kind_t   kind_r, kind_nxt;
  logic [7:0]        marker_r, marker_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  lerb_pkg::result_t hold_r, hold_nxt;
  logic [7:0]        rdata_r;

  logic [7:0]        mem [DEPTH];
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     raddr;

  logic              key_fire, rd_fire, is_bs, ignored, pend_any, do_bs, do_store;
  logic [7:0]        store_byte, term_byte;
  logic              is_term, line_mode;
  logic [6:0]        n_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign key_fire  = in_ready && in_valid && (in_item.opcode != lerb_pkg::OP_READ);
  assign rd_fire   = in_ready && in_valid && (in_item.opcode == lerb_pkg::OP_READ);
  assign is_bs     = (in_item.opcode == lerb_pkg::OP_KEY) &&
                     (in_item.key_byte == lerb_pkg::KEY_BS);
  assign ignored   = (in_item.opcode == lerb_pkg::OP_KEY) &&
                     ((in_item.key_byte == lerb_pkg::KEY_ETX) ||
                      (in_item.key_byte == lerb_pkg::KEY_FF)  ||
                      (in_item.key_byte == lerb_pkg::KEY_ESC));
  assign pend_any  = tab_r || up_r || down_r;
  assign do_bs     = (key_fire && is_bs) ||
                     (rd_fire && (in_item.max_length != '0) && pend_any);
  assign do_store  = key_fire && !is_bs && !ignored && (free_r != '0);
  assign line_mode = (kind_r == lerb_pkg::KIND_LINE);
  assign raddr     = line_mode ? ri_r : ptr_r;
  assign n_inc     = n_r + 7'd1;

  always_comb begin
    unique case (in_item.opcode)
      lerb_pkg::OP_UP:   store_byte = lerb_pkg::MARK_UP;
      lerb_pkg::OP_DOWN: store_byte = lerb_pkg::MARK_DOWN;
      default:           store_byte = in_item.key_byte;
    endcase
  end

  // single byte compare shared by line and preview walks
  assign term_byte = line_mode ? lerb_pkg::KEY_CR : marker_r;
  assign is_term   = (rdata_r == term_byte);

  always_comb begin
    state_nxt      = state_r;
    wi_nxt         = wi_r;
    ri_nxt         = ri_r;
    ptr_nxt        = ptr_r;
    free_nxt       = free_r;
    lc_nxt         = lc_r;
    tab_nxt        = tab_r;
    up_nxt         = up_r;
    down_nxt       = down_r;
    ac_nxt         = cfg_we ? cfg_autocomplete : ac_r;
    len_nxt        = len_r;
    n_nxt          = n_r;
    kind_nxt       = kind_r;
    marker_nxt     = marker_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    mem_we         = 1'b0;
    mem_wdata      = store_byte;
    emit           = 1'b0;
    emit_res       = hold_r;

    if (do_bs && (free_r < FULL)) begin
      wi_nxt   = idx_prev(wi_r);
      free_nxt = free_r + 1'b1;
    end

    if (do_store) begin
      mem_we   = 1'b1;
      free_nxt = free_r - 1'b1;
      wi_nxt   = idx_next(wi_r);
      if (store_byte == lerb_pkg::KEY_CR) begin
        if (lc_r != lerb_pkg::LC_MAX) lc_nxt = lc_r + 7'd1;
      end else if (store_byte == lerb_pkg::KEY_TAB && ac_r) begin
        tab_nxt = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (key_fire && in_item.opcode == lerb_pkg::OP_UP) up_nxt = 1'b1;
        if (key_fire && in_item.opcode == lerb_pkg::OP_DOWN) down_nxt = 1'b1;
        if (rd_fire) begin
          len_nxt        = (in_item.max_length > lerb_pkg::LEN_MAX) ?
                           lerb_pkg::LEN_MAX : in_item.max_length;
          n_nxt          = '0;
          hold_valid_nxt = 1'b0;
          ptr_nxt        = ri_r;
          priority if (in_item.max_length == '0) begin
            kind_nxt  = lerb_pkg::KIND_LINE;
            state_nxt = S_FIN;
          end else if (tab_r) begin
            kind_nxt   = lerb_pkg::KIND_TAB;
            marker_nxt = lerb_pkg::KEY_TAB;
            tab_nxt    = 1'b0;
            state_nxt  = S_RD;
          end else if (up_r) begin
            kind_nxt   = lerb_pkg::KIND_UP;
            marker_nxt = lerb_pkg::MARK_UP;
            up_nxt     = 1'b0;
            state_nxt  = S_RD;
          end else if (down_r) begin
            kind_nxt   = lerb_pkg::KIND_DOWN;
            marker_nxt = lerb_pkg::MARK_DOWN;
            down_nxt   = 1'b0;
            state_nxt  = S_RD;
          end else if (lc_r == '0) begin
            kind_nxt  = lerb_pkg::KIND_NOT_READY;
            state_nxt = S_FIN;
          end else begin
            kind_nxt  = lerb_pkg::KIND_LINE;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (is_term) begin
          if (line_mode) begin
            ri_nxt = idx_next(ri_r);
            if (free_r < FULL) free_nxt = free_r + 1'b1;
            if (lc_r != '0) lc_nxt = lc_r - 7'd1;
          end
          state_nxt = S_FIN;
        end else if (!hold_valid_r || out_free) begin
          emit                = hold_valid_r;
          hold_nxt.data_byte  = rdata_r;
          hold_nxt.data_valid = 1'b1;
          hold_nxt.last       = 1'b0;
          hold_nxt.read_kind  = kind_r;
          hold_nxt.byte_count = n_inc;
          hold_valid_nxt      = 1'b1;
          n_nxt               = n_inc;
          if (line_mode) begin
            ri_nxt = idx_next(ri_r);
            if (free_r < FULL) free_nxt = free_r + 1'b1;
          end else begin
            ptr_nxt = idx_next(ptr_r);
          end
          state_nxt = (n_inc == len_r) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (hold_valid_r) begin
            emit_res.last = 1'b1;
          end else begin
            emit_res.data_byte  = '0;
            emit_res.data_valid = 1'b0;
            emit_res.last       = 1'b1;
            emit_res.read_kind  = kind_r;
            emit_res.byte_count = '0;
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wi_r         <= '0;
      ri_r         <= '0;
      ptr_r        <= '0;
      free_r       <= FULL;
      lc_r         <= '0;
      tab_r        <= 1'b0;
      up_r         <= 1'b0;
      down_r       <= 1'b0;
      ac_r         <= 1'b0;
      len_r        <= '0;
      n_r          <= '0;
      kind_r       <= lerb_pkg::KIND_LINE;
      marker_r     <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wi_r         <= wi_nxt;
      ri_r         <= ri_nxt;
      ptr_r        <= ptr_nxt;
      free_r       <= free_nxt;
      lc_r         <= lc_nxt;
      tab_r        <= tab_nxt;
      up_r         <= up_nxt;
      down_r       <= down_nxt;
      ac_r         <= ac_nxt;
      len_r        <= len_nxt;
      n_r          <= n_nxt;
      kind_r       <= kind_nxt;
      marker_r     <= marker_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wi_r] <= mem_wdata;
    if (state_r == S_RD) rdata_r <= mem[raddr];
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FULL)
    else $error("free slot count above depth");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> (hold_r.byte_count == n_r) && (n_r != '0))
    else $error("held byte count out of step with walk");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result issued into a full output register");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |=> !in_ready)
    else $error("ready while a read request is in progress");

  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (n_r < len_r))
    else $error("walk past requested length");

endmodule

// File: rtl/core/line_edit_ring_buffer.sv
// Keyboard line-editing ring buffer.
// in channel: one transaction per key, arrow or read request; opcode in tuser.
// Key, arrow up and arrow down transactions give no result and leave the block
// ready; in_tready stays high for them.
// A read request gives one or more result transactions on the out channel,
// the final one flagged by tlast. The store is walked one byte per step, each
// step a read on the one memory read port and a registered compare. After a read
// is accepted, in_tready stays low until the last result is loaded into the
// output register, so no new transaction is taken during the walk.
// With nothing pending and a nonzero max_length the read answers with read_kind
// "not ready"; that result is loaded into the output register once it is free.
// cfg channel: autocomplete enable, always ready; write it only while idle.
// Reset (synchronous, rst_n low) empties the buffer and clears all flags and
// the enable; the store contents are not cleared.
// When the receiver stalls, the output register holds its result and the
// walk pauses until it drains; nothing is dropped.
module line_edit_ring_buffer #(
  parameter int DEPTH = lerb_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_byte[7:0], max_length[14:8], zero[15]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_byte[7:0], data_valid[8], byte_count[15:9]
  output logic        out_tlast,
  output logic [2:0]  out_tuser,  // read_kind[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  lerb_pkg::item_t   item;
  lerb_pkg::result_t emit_res;
  lerb_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              out_free;
  logic              emit;

  assign item.opcode     = lerb_pkg::opcode_t'(in_tuser);
  assign item.key_byte   = in_tdata[7:0];
  assign item.max_length = in_tdata[14:8];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  lerb_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_item          (item),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_autocomplete (cfg_data),
    .out_free         (out_free),
    .emit             (emit),
    .emit_res         (emit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
    if (out_free && emit) out_res_r <= emit_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.byte_count, out_res_r.data_valid, out_res_r.data_byte};
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.read_kind;

endmodule
